[sv/sfq_pkg.sv]
// Package for the start-time fair queueing rank scheduler.
// Holds sizes, the operation codes, the request/response/command types and the back part's states. No dependencies.
package sfq_pkg;
    localparam int QueueDepth = 64;
    localparam int MaxFlows   = 8;
    localparam int QAW        = $clog2(QueueDepth);
    localparam int FAW        = (MaxFlows > 1) ? $clog2(MaxFlows) : 1;
    localparam int CfgRegs    = 8;
    localparam int PAW        = 5;
    localparam logic [30:0] RankMax = 31'h7FFF_FFFF;

    typedef enum logic {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } t_func;

    typedef struct packed {
        logic        func;
        logic [47:0] flow_key;
        logic [15:0] packet_ref;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic        dropped;
        logic        was_empty;
        logic [15:0] out_packet_ref;
        logic [30:0] pkt_rank;
        logic [31:0] pkt_uid;
        logic [2:0]  flow_slot;
        logic        new_flow;
        logic        table_full;
        logic [31:0] inversion_mag;
        logic [31:0] inversion_events;
        logic [31:0] drop_total;
    } t_rsp;

    // Classified command handed from front to back.
    typedef struct packed {
        logic           deq;
        logic           tbl_full;
        logic           new_flow;
        logic [FAW-1:0] slot;
        logic [15:0]    packet_ref;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ,
        ST_DEQ_RD,
        ST_WALK,
        ST_WALK_LAST,
        ST_DONE
    } t_state;
endpackage

[sv/sfq_if.sv]
// Valid/ready channel interfaces for the scheduler.
// Depends on sfq_pkg for the request and response payload types.
interface sfq_req_if (input logic i_clk);
    logic          valid;
    logic          ready;
    sfq_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sfq_rsp_if (input logic i_clk);
    logic          valid;
    logic          ready;
    sfq_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/sfq_front.sv]
// Front part: accepts requests, looks up and allocates flow slots.
// Depends on sfq_pkg; feeds a two-entry command queue toward sfq_back.
module sfq_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sfq_pkg::t_req        i_req,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output sfq_pkg::t_cmd        o_cmd
);
    logic [47:0]                  r_keys [sfq_pkg::MaxFlows];
    logic [sfq_pkg::FAW:0]        r_used;
    sfq_pkg::t_cmd                r_q [2];
    logic                         r_wp, r_rp;
    logic [1:0]                   r_cnt;
    logic                         w_fire, w_pop, w_found;
    logic [sfq_pkg::FAW-1:0]      w_hit;
    sfq_pkg::t_cmd                w_cmd;

    assign o_ready     = (r_cnt != 2'd2);
    assign w_fire      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        w_found = 1'b0;
        w_hit   = '0;
        for (int i = sfq_pkg::MaxFlows - 1; i >= 0; i--) begin
            if ((i < r_used) && (r_keys[i] == i_req.flow_key)) begin
                w_found = 1'b1;
                w_hit   = sfq_pkg::FAW'(i);
            end
        end
        w_cmd.deq        = (i_req.func == sfq_pkg::FUNC_DEQ);
        w_cmd.packet_ref = i_req.packet_ref;
        w_cmd.tbl_full   = !w_found && (r_used == (sfq_pkg::FAW+1)'(sfq_pkg::MaxFlows));
        w_cmd.new_flow   = !w_found && !w_cmd.tbl_full;
        w_cmd.slot       = w_found ? w_hit : (w_cmd.tbl_full ? '0 : r_used[sfq_pkg::FAW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_fire) begin
                r_wp <= ~r_wp;
                if (!w_cmd.deq && w_cmd.new_flow) begin
                    r_used <= r_used + 1'b1;
                end
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_fire} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_q[r_wp] <= w_cmd;
            if (!w_cmd.deq && w_cmd.new_flow) begin
                r_keys[w_cmd.slot] <= i_req.flow_key;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= (sfq_pkg::FAW+1)'(sfq_pkg::MaxFlows))
        else $error("flow count overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !o_ready)
        else $error("queue full but ready");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count slip");
endmodule

[sv/sfq_back.sv]
// Back part: ranks and stores enqueues, pops and walks the FIFO on dequeue.
// Depends on sfq_pkg; takes commands from sfq_front, weights from the config port.
module sfq_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  sfq_pkg::t_cmd        i_cmd,
    input  logic [15:0]          i_weight [sfq_pkg::MaxFlows],
    output logic                 o_valid,
    input  logic                 i_ready,
    output sfq_pkg::t_rsp        o_rsp
);
    localparam int QA = sfq_pkg::QAW;
    localparam int QC = QA + 1;
    localparam int MW = 32 + QA;

    logic [15:0]  m_pkt  [sfq_pkg::QueueDepth];
    logic [30:0]  m_rank [sfq_pkg::QueueDepth];
    logic [31:0]  m_uid  [sfq_pkg::QueueDepth];
    logic [2:0]   m_flow [sfq_pkg::QueueDepth];

    sfq_pkg::t_state r_st, n_st;
    sfq_pkg::t_cmd   r_cmd;
    logic [QA-1:0] r_head, r_tail, r_wptr;
    logic [QC-1:0] r_count, r_left;
    logic [30:0]   r_round, r_drank;
    logic [31:0]   r_uid, r_drops, r_invs;
    logic [63:0]   r_isum;
    logic [MW-1:0] r_mag;
    logic [30:0]   r_finish [sfq_pkg::MaxFlows];
    logic [30:0]   r_rd_rank;
    logic [15:0]   r_rd_pkt;
    logic [31:0]   r_rd_uid;
    logic [2:0]    r_rd_flow;
    logic [QA-1:0] w_rd_addr;
    sfq_pkg::t_rsp r_work;
    sfq_pkg::t_rsp r_rsp;
    logic          r_ovalid;

    logic [30:0]   w_fin, w_rank;
    logic [31:0]   w_sum;
    logic [30:0]   w_gap;
    logic [MW-1:0] w_mag;
    logic          w_room, w_out_free;
    sfq_pkg::t_rsp w_enq_rsp, w_deq_rsp, w_done_rsp;

    function automatic logic [QA-1:0] f_next(input logic [QA-1:0] p);
        logic [QC-1:0] q;
        q = {1'b0, p} + 1'b1;
        return (q >= QC'(sfq_pkg::QueueDepth)) ? '0 : q[QA-1:0];
    endfunction

    assign o_cmd_ready = (r_st == sfq_pkg::ST_IDLE);
    assign o_valid     = r_ovalid;
    assign o_rsp       = r_rsp;

    assign w_fin  = i_cmd.new_flow ? 31'd0 : r_finish[i_cmd.slot];
    assign w_rank = (r_finish[r_cmd.slot] > r_round) && !r_cmd.new_flow
                    ? r_finish[r_cmd.slot] : r_round;
    assign w_sum  = {1'b0, w_rank} + {16'd0, i_weight[r_cmd.slot]};
    assign w_gap  = (r_drank > r_rd_rank) ? (r_drank - r_rd_rank) : 31'd0;
    assign w_mag  = r_mag + MW'(w_gap);
    assign w_room = (r_count < QC'(sfq_pkg::QueueDepth));
    assign w_out_free = !r_ovalid || i_ready;

    always_comb begin
        unique case (r_st)
            sfq_pkg::ST_IDLE, sfq_pkg::ST_DONE: w_rd_addr = r_head;
            default:                            w_rd_addr = r_wptr;
        endcase
    end

    always_comb begin
        w_enq_rsp = '0;
        w_enq_rsp.inversion_events = r_invs;
        w_enq_rsp.drop_total       = r_drops;
        if (r_cmd.tbl_full) begin
            w_enq_rsp.dropped    = 1'b1;
            w_enq_rsp.table_full = 1'b1;
            w_enq_rsp.drop_total = r_drops + 32'd1;
        end else begin
            w_enq_rsp.pkt_rank  = w_rank;
            w_enq_rsp.pkt_uid   = r_uid + 32'd1;
            w_enq_rsp.flow_slot = 3'(r_cmd.slot);
            w_enq_rsp.new_flow  = r_cmd.new_flow;
            if (w_room) begin
                w_enq_rsp.accepted = 1'b1;
            end else begin
                w_enq_rsp.dropped    = 1'b1;
                w_enq_rsp.drop_total = r_drops + 32'd1;
            end
        end

        w_deq_rsp = '0;
        w_deq_rsp.inversion_events = r_invs;
        w_deq_rsp.drop_total       = r_drops;
        if (r_count == '0) begin
            w_deq_rsp.was_empty = 1'b1;
        end else begin
            w_deq_rsp.out_packet_ref = r_rd_pkt;
            w_deq_rsp.pkt_rank       = r_rd_rank;
            w_deq_rsp.pkt_uid        = r_rd_uid;
            w_deq_rsp.flow_slot      = r_rd_flow;
        end

        w_done_rsp = r_work;
        if (r_cmd.deq && !r_work.was_empty) begin
            w_done_rsp.inversion_mag = (|r_mag[MW-1:32]) ? 32'hFFFF_FFFF : r_mag[31:0];
            if (r_mag != '0) begin
                w_done_rsp.inversion_events = r_invs + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_rank <= m_rank[w_rd_addr];
        r_rd_pkt  <= m_pkt[w_rd_addr];
        r_rd_uid  <= m_uid[w_rd_addr];
        r_rd_flow <= m_flow[w_rd_addr];
        if (r_st == sfq_pkg::ST_ENQ && !r_cmd.tbl_full && w_room) begin
            m_pkt[r_tail]  <= r_cmd.packet_ref;
            m_rank[r_tail] <= w_rank;
            m_uid[r_tail]  <= r_uid + 32'd1;
            m_flow[r_tail] <= 3'(r_cmd.slot);
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            sfq_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_st = i_cmd.deq ? sfq_pkg::ST_DEQ_RD : sfq_pkg::ST_ENQ;
                end
            end
            sfq_pkg::ST_ENQ:    n_st = sfq_pkg::ST_DONE;
            sfq_pkg::ST_DEQ_RD: n_st = (r_count == '0) ? sfq_pkg::ST_DONE
                                     : (r_count == QC'(1)) ? sfq_pkg::ST_WALK_LAST
                                     : sfq_pkg::ST_WALK;
            sfq_pkg::ST_WALK:   n_st = (r_left == QC'(1)) ? sfq_pkg::ST_WALK_LAST
                                                          : sfq_pkg::ST_WALK;
            sfq_pkg::ST_WALK_LAST: n_st = sfq_pkg::ST_DONE;
            sfq_pkg::ST_DONE:   n_st = w_out_free ? sfq_pkg::ST_IDLE
                                                  : sfq_pkg::ST_DONE;
            default:            n_st = sfq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= sfq_pkg::ST_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_round  <= '0;
            r_uid    <= '0;
            r_drops  <= '0;
            r_invs   <= '0;
            r_isum   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < sfq_pkg::MaxFlows; i++) r_finish[i] <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == sfq_pkg::ST_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                sfq_pkg::ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        if (!i_cmd.deq && i_cmd.new_flow) r_finish[i_cmd.slot] <= w_fin;
                    end
                end
                sfq_pkg::ST_ENQ: begin
                    r_work <= w_enq_rsp;
                    if (r_cmd.tbl_full) begin
                        r_drops <= r_drops + 32'd1;
                    end else begin
                        r_uid <= r_uid + 32'd1;
                        if (w_room) begin
                            r_tail               <= f_next(r_tail);
                            r_count              <= r_count + 1'b1;
                            r_finish[r_cmd.slot] <= w_sum[31] ? sfq_pkg::RankMax
                                                              : w_sum[30:0];
                        end else begin
                            r_drops <= r_drops + 32'd1;
                        end
                    end
                end
                sfq_pkg::ST_DEQ_RD: begin
                    r_work <= w_deq_rsp;
                    r_mag  <= '0;
                    if (r_count != '0) begin
                        r_drank <= r_rd_rank;
                        r_round <= r_rd_rank;
                        r_head  <= f_next(r_head);
                        r_count <= r_count - 1'b1;
                        r_left  <= r_count - 1'b1;
                        r_wptr  <= f_next(r_head);
                    end
                end
                sfq_pkg::ST_WALK: begin
                    r_wptr <= f_next(r_wptr);
                    r_left <= r_left - 1'b1;
                    if (r_left != r_count) begin
                        r_mag <= w_mag;
                    end
                end
                sfq_pkg::ST_WALK_LAST: begin
                    if (r_count != '0) begin
                        r_mag <= w_mag;
                    end
                end
                sfq_pkg::ST_DONE: begin
                    if (w_out_free) begin
                        r_rsp <= w_done_rsp;
                        if (r_cmd.deq && !r_work.was_empty && r_mag != '0) begin
                            r_invs <= r_invs + 32'd1;
                            r_isum <= (r_isum > ~64'(r_mag)) ? '1
                                      : r_isum + 64'(r_mag);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QC'(sfq_pkg::QueueDepth))
        else $error("queue count overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_rsp))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == sfq_pkg::ST_DONE && r_cmd.deq) |-> !(r_work.accepted || r_work.dropped))
        else $error("dequeue flagged as enqueue");
endmodule

[sv/sfq_rank_fifo_scheduler.sv]
// Top level of the start-time fair queueing rank scheduler.
// An enqueue passes through ST_ENQ and ST_DONE; a dequeue reads the head in ST_DEQ_RD, then
// walks the queued packets left with one read per cycle over the rank memory before ST_DONE.
// Throughput: one request at a time in the back part; a stalled response holds
// the back part, and the front queue holds two requests.
// Reset: synchronous active low; clears pointers, counters, rounds, weights to 1.
module sfq_rank_fifo_scheduler (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    sfq_req_if.sink                in_req,
    sfq_rsp_if.source              out_rsp,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [sfq_pkg::PAW-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    logic [15:0]   r_weight [sfq_pkg::MaxFlows];
    logic          w_cmd_valid, w_cmd_ready;
    sfq_pkg::t_cmd w_cmd;
    logic [2:0]    w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign prdata = {16'd0, r_weight[w_idx]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sfq_pkg::MaxFlows; i++) r_weight[i] <= 16'd1;
        end else if (psel && penable && pwrite && pready) begin
            r_weight[w_idx] <= pwdata[15:0];
        end
    end

    sfq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_req.valid),
        .o_ready     (in_req.ready),
        .i_req       (in_req.payload),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    sfq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_weight    (r_weight),
        .o_valid     (out_rsp.valid),
        .i_ready     (out_rsp.ready),
        .o_rsp       (out_rsp.payload)
    );
endmodule
